[hw/rtl/tilt_motor_bang_bang_assert.svh]
// Assertion macros shared by the tilt motor controller RTL.
// Each macro expands to one labeled concurrent assertion that is clocked on the
// rising edge and disabled while the active-low reset is asserted.
`ifndef TILT_MOTOR_BANG_BANG_ASSERT_SVH
`define TILT_MOTOR_BANG_BANG_ASSERT_SVH

// Same-cycle implication.
`define TMBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TMBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tmbb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmbb_pkg
// Types and constants for the tilt-driven three-motor bang-bang controller.
// ----------------------------------------------------------------------------
package tmbb_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int NUM_MOTORS = 3;
    localparam int NUM_STAGES = 5;
    localparam int DB_SHIFT   = 13;  // deadband is scaled by 8192

    typedef logic signed [SAMPLE_W-1:0] tmbb_sample_t;

    typedef struct packed {
        logic signed [15:0] gx;
        logic signed [15:0] gy;
    } tmbb_dir_t;

    // per-lane stage loads
    typedef struct packed {
        logic acc;      // item accepted: shift line and running sum
        logic ld_div;   // reciprocal multiply stage
        logic ld_mean;  // mean register
    } tmbb_lane_ctl_t;

    // merge stage loads
    typedef struct packed {
        logic ld_prod;  // gain products
        logic ld_out;   // output register
    } tmbb_merge_ctl_t;

    typedef enum logic [2:0] {
        REG_DEADBAND = 3'd0,
        REG_M1_GX    = 3'd1,
        REG_M1_GY    = 3'd2,
        REG_M2_GX    = 3'd3,
        REG_M2_GY    = 3'd4,
        REG_M3_GX    = 3'd5,
        REG_M3_GY    = 3'd6
    } tmbb_reg_e;

    localparam logic [15:0]        DEADBAND_RESET = 16'd979;
    localparam logic signed [15:0] M1_GX_RESET    = 16'sd16384;
    localparam logic signed [15:0] M1_GY_RESET    = 16'sd0;
    localparam logic signed [15:0] M2_GX_RESET    = -16'sd8192;
    localparam logic signed [15:0] M2_GY_RESET    = -16'sd14189;
    localparam logic signed [15:0] M3_GX_RESET    = -16'sd8192;
    localparam logic signed [15:0] M3_GY_RESET    = 16'sd14189;

endpackage

[hw/rtl/tmbb_axis_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmbb_axis_lane
// One axis: shift-line window, running sum and truncating mean by reciprocal.
// ----------------------------------------------------------------------------
module tmbb_axis_lane #(
    parameter int WINDOW_LENGTH = 5
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tmbb_pkg::tmbb_lane_ctl_t     ctl,
    input  tmbb_pkg::tmbb_sample_t       sample,
    output tmbb_pkg::tmbb_sample_t       mean
);
    import tmbb_pkg::*;

    localparam int LOG_W  = $clog2(WINDOW_LENGTH);
    localparam int SUM_W  = SAMPLE_W + LOG_W;
    localparam int SHIFT  = SUM_W + LOG_W;
    localparam int RCP_W  = SHIFT + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam int QUO_W  = SAMPLE_W + 1;
    // ceil(2^SHIFT / W): exact floor division for all |sum| < 2^SUM_W
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);

    tmbb_sample_t              line_reg [WINDOW_LENGTH];
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:0]          mag;
    logic [PROD_W-1:0]         prod_reg;
    logic [PROD_W-1:0]         prod_next;
    logic                      neg_reg;
    logic [QUO_W-1:0]          quo;
    logic [QUO_W-1:0]          quo_signed;
    tmbb_sample_t              mean_reg;
    tmbb_sample_t              mean_next;

    // oldest sample leaves the window as the new one enters
    assign sum_next = sum_reg - SUM_W'(line_reg[WINDOW_LENGTH-1]) + SUM_W'(sample);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
                line_reg[i] <= '0;
            end
            sum_reg <= '0;
        end else if (ctl.acc) begin
            line_reg[0] <= sample;
            for (int i = 1; i < WINDOW_LENGTH; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
            sum_reg <= sum_next;
        end
    end

    // divide magnitude so the quotient truncates toward zero
    assign mag       = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign prod_next = PROD_W'(mag) * PROD_W'(RCP);

    always_ff @(posedge aclk) begin
        if (ctl.ld_div) begin
            prod_reg <= prod_next;
            neg_reg  <= sum_reg[SUM_W-1];
        end
    end

    assign quo        = prod_reg[SHIFT +: QUO_W];
    assign quo_signed = neg_reg ? QUO_W'(-quo) : quo;
    assign mean_next  = quo_signed[SAMPLE_W-1:0];

    always_ff @(posedge aclk) begin
        if (ctl.ld_mean) begin
            mean_reg <= mean_next;
        end
    end

    assign mean = mean_reg;

endmodule

[hw/rtl/tmbb_motor_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmbb_motor_merge
// Merges the axis means: projects x/y onto three motor directions and makes
// the on/reverse decisions; holds the output register.
// ----------------------------------------------------------------------------
module tmbb_motor_merge (
    input  logic                                          aclk,
    input  tmbb_pkg::tmbb_merge_ctl_t                     ctl,
    input  tmbb_pkg::tmbb_sample_t                        mean_x_in,
    input  tmbb_pkg::tmbb_sample_t                        mean_y_in,
    input  tmbb_pkg::tmbb_sample_t                        mean_z_in,
    input  tmbb_pkg::tmbb_dir_t [tmbb_pkg::NUM_MOTORS-1:0] dirs,
    input  logic [15:0]                                   deadband,
    output tmbb_pkg::tmbb_sample_t                        mean_x,
    output tmbb_pkg::tmbb_sample_t                        mean_y,
    output tmbb_pkg::tmbb_sample_t                        mean_z,
    output logic [tmbb_pkg::NUM_MOTORS-1:0]               motor_on,
    output logic [tmbb_pkg::NUM_MOTORS-1:0]               motor_rev
);
    import tmbb_pkg::*;

    localparam int PROJ_W = 33;

    logic signed [31:0]       px_reg [NUM_MOTORS];
    logic signed [31:0]       py_reg [NUM_MOTORS];
    tmbb_sample_t             mx_reg;
    tmbb_sample_t             my_reg;
    tmbb_sample_t             mz_reg;
    logic signed [PROJ_W-1:0] proj [NUM_MOTORS];
    logic [PROJ_W-1:0]        proj_mag [NUM_MOTORS];
    logic [PROJ_W-1:0]        thr;
    logic [NUM_MOTORS-1:0]    on_next;
    logic [NUM_MOTORS-1:0]    rev_next;
    tmbb_sample_t             out_x_reg;
    tmbb_sample_t             out_y_reg;
    tmbb_sample_t             out_z_reg;
    logic [NUM_MOTORS-1:0]    on_reg;
    logic [NUM_MOTORS-1:0]    rev_reg;

    always_ff @(posedge aclk) begin
        if (ctl.ld_prod) begin
            for (int k = 0; k < NUM_MOTORS; k++) begin
                px_reg[k] <= 32'(dirs[k].gx) * 32'(mean_x_in);
                py_reg[k] <= 32'(dirs[k].gy) * 32'(mean_y_in);
            end
            mx_reg <= mean_x_in;
            my_reg <= mean_y_in;
            mz_reg <= mean_z_in;
        end
    end

    assign thr = PROJ_W'({deadband, {DB_SHIFT{1'b0}}});

    always_comb begin
        for (int k = 0; k < NUM_MOTORS; k++) begin
            proj[k]     = PROJ_W'(px_reg[k]) + PROJ_W'(py_reg[k]);
            proj_mag[k] = proj[k][PROJ_W-1] ? PROJ_W'(-proj[k]) : PROJ_W'(proj[k]);
            on_next[k]  = proj_mag[k] > thr;
            rev_next[k] = proj[k][PROJ_W-1] || (proj[k] == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_out) begin
            out_x_reg <= mx_reg;
            out_y_reg <= my_reg;
            out_z_reg <= mz_reg;
            on_reg    <= on_next;
            rev_reg   <= rev_next;
        end
    end

    assign mean_x    = out_x_reg;
    assign mean_y    = out_y_reg;
    assign mean_z    = out_z_reg;
    assign motor_on  = on_reg;
    assign motor_rev = rev_reg;

endmodule

[hw/rtl/tilt_motor_bang_bang.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_motor_bang_bang
// Windowed accelerometer means driving three bang-bang motor decisions.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one three-axis sample per item (valid/ready).
//   m_* channel: one result per item: three window means and an on/reverse
//   pair per motor (valid/ready).
//   cfg_*: write-only register port, one write per cycle with cfg_wr_en;
//   write only while no item is in flight. Index 7 is ignored.
// Timing:
//   Five pipeline stages: running sum, reciprocal multiply, mean, gain
//   products, add/compare. An accepted item passes through these stages in
//   that order; one item per cycle is sustained while m_ready is high. The
//   window sum is a running sum, so the only per-item loop is the sum update.
// Reset:
//   aresetn (synchronous) empties the pipeline, zeroes the windows and sums,
//   and loads the default deadband and motor directions.
// Stall:
//   While m_ready is low the result holds; earlier stages keep filling until
//   every stage holds an item, then s_ready drops.
// ----------------------------------------------------------------------------
`include "tilt_motor_bang_bang_assert.svh"

module tilt_motor_bang_bang #(
    parameter int WINDOW_LENGTH = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tmbb_pkg::tmbb_sample_t s_accel_x,
    input  tmbb_pkg::tmbb_sample_t s_accel_y,
    input  tmbb_pkg::tmbb_sample_t s_accel_z,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tmbb_pkg::tmbb_sample_t m_mean_x,
    output tmbb_pkg::tmbb_sample_t m_mean_y,
    output tmbb_pkg::tmbb_sample_t m_mean_z,
    output logic                   m_motor1_on,
    output logic                   m_motor1_reverse,
    output logic                   m_motor2_on,
    output logic                   m_motor2_reverse,
    output logic                   m_motor3_on,
    output logic                   m_motor3_reverse,
    input  logic                   cfg_wr_en,
    input  logic [2:0]             cfg_addr,
    input  logic [15:0]            cfg_wdata
);
    import tmbb_pkg::*;

    logic [15:0]                  deadband_reg;
    logic [15:0]                  deadband_next;
    tmbb_dir_t [NUM_MOTORS-1:0]   dir_reg;
    tmbb_dir_t [NUM_MOTORS-1:0]   dir_next;

    logic [NUM_STAGES-1:0]        v_reg;
    logic [NUM_STAGES-1:0]        v_next;
    logic [NUM_STAGES:0]          rdy;
    logic [NUM_STAGES-1:0]        load;

    tmbb_lane_ctl_t               lane_ctl;
    tmbb_merge_ctl_t              merge_ctl;
    tmbb_sample_t                 lane_mean_x;
    tmbb_sample_t                 lane_mean_y;
    tmbb_sample_t                 lane_mean_z;
    logic [NUM_MOTORS-1:0]        motor_on;
    logic [NUM_MOTORS-1:0]        motor_rev;

    // ---------------- configuration registers ----------------
    always_comb begin
        deadband_next = deadband_reg;
        dir_next      = dir_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_DEADBAND: deadband_next   = cfg_wdata;
                REG_M1_GX:    dir_next[0].gx  = cfg_wdata;
                REG_M1_GY:    dir_next[0].gy  = cfg_wdata;
                REG_M2_GX:    dir_next[1].gx  = cfg_wdata;
                REG_M2_GY:    dir_next[1].gy  = cfg_wdata;
                REG_M3_GX:    dir_next[2].gx  = cfg_wdata;
                REG_M3_GY:    dir_next[2].gy  = cfg_wdata;
                default:      deadband_next   = deadband_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg <= DEADBAND_RESET;
            dir_reg[0]   <= '{gx: M1_GX_RESET, gy: M1_GY_RESET};
            dir_reg[1]   <= '{gx: M2_GX_RESET, gy: M2_GY_RESET};
            dir_reg[2]   <= '{gx: M3_GX_RESET, gy: M3_GY_RESET};
        end else begin
            deadband_reg <= deadband_next;
            dir_reg      <= dir_next;
        end
    end

    // ---------------- pipeline occupancy ----------------
    // a stage loads when it is empty or its item moves on this cycle
    always_comb begin
        rdy[NUM_STAGES] = m_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        load[0] = s_valid && rdy[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            load[k] = v_reg[k-1] && rdy[k];
        end
        for (int k = 0; k < NUM_STAGES; k++) begin
            v_next[k] = load[k] || (v_reg[k] && !rdy[k+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = v_reg[NUM_STAGES-1];

    assign lane_ctl.acc      = load[0];
    assign lane_ctl.ld_div   = load[1];
    assign lane_ctl.ld_mean  = load[2];
    assign merge_ctl.ld_prod = load[3];
    assign merge_ctl.ld_out  = load[4];

    // ---------------- axis lanes ----------------
    tmbb_axis_lane #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_lane_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lane_ctl),
        .sample  (s_accel_x),
        .mean    (lane_mean_x)
    );

    tmbb_axis_lane #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_lane_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lane_ctl),
        .sample  (s_accel_y),
        .mean    (lane_mean_y)
    );

    tmbb_axis_lane #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_lane_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lane_ctl),
        .sample  (s_accel_z),
        .mean    (lane_mean_z)
    );

    // ---------------- motor merge ----------------
    tmbb_motor_merge u_merge (
        .aclk      (aclk),
        .ctl       (merge_ctl),
        .mean_x_in (lane_mean_x),
        .mean_y_in (lane_mean_y),
        .mean_z_in (lane_mean_z),
        .dirs      (dir_reg),
        .deadband  (deadband_reg),
        .mean_x    (m_mean_x),
        .mean_y    (m_mean_y),
        .mean_z    (m_mean_z),
        .motor_on  (motor_on),
        .motor_rev (motor_rev)
    );

    assign m_motor1_on      = motor_on[0];
    assign m_motor1_reverse = motor_rev[0];
    assign m_motor2_on      = motor_on[1];
    assign m_motor2_reverse = motor_rev[1];
    assign m_motor3_on      = motor_on[2];
    assign m_motor3_reverse = motor_rev[2];

    // ---------------- assertions ----------------
    `TMBB_ASSERT_NOW(a_ready_chain, aclk, aresetn, m_ready, s_ready,
        "s_ready low while the result side is ready")
    `TMBB_ASSERT_NEXT(a_accept_fills, aclk, aresetn, s_valid && s_ready, v_reg[0],
        "accepted item did not enter the first stage")
    `TMBB_ASSERT_NEXT(a_out_source, aclk, aresetn,
        !v_reg[NUM_STAGES-2] && !(m_valid && !m_ready), !m_valid,
        "result appeared without an item in the product stage")
    `TMBB_ASSERT_NOW(a_empty_ready, aclk, aresetn, !v_reg[0], s_ready,
        "input stalled with the first stage empty")

endmodule
